// ----- src/cdg_pkg.sv -----
// shared constants, coefficient table and rounding helper for the gradient block
`timescale 1ns / 1ps
`default_nettype none
package cdg_pkg;

  localparam int HALO       = 4;
  localparam int LINES      = 2 * HALO;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int SAMPLE_W   = 32;
  localparam int OUT_W      = SAMPLE_W + 2;
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int COEF_W     = 25;
  localparam int FRAC_W     = 24;
  localparam int PROD_W     = DIFF_W + COEF_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int LANE_W     = 3;
  localparam int WORD_W     = LINES * SAMPLE_W;
  localparam int ORDER_W    = 3;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd2;
  localparam logic [FW_W-1:0]    FW_RESET    = 11'd1024;
  localparam logic [FH_W-1:0]    FH_RESET    = 13'd1024;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [OUT_W-1:0]    grad_t;

  // q24 coefficient for order n, tap k (zero past the order)
  function automatic coef_t coef(input logic [ORDER_W-1:0] n, input logic [2:0] k);
    coef_t c;
    c = '0;
    case (n)
      3'd1: begin
        if (k == 3'd1) c = 25'sd8388608;
      end
      3'd2: begin
        if (k == 3'd1) c = 25'sd11184811;
        if (k == 3'd2) c = -25'sd1398101;
      end
      3'd3: begin
        if (k == 3'd1) c = 25'sd12582912;
        if (k == 3'd2) c = -25'sd2516582;
        if (k == 3'd3) c = 25'sd279620;
      end
      default: begin
        if (k == 3'd1) c = 25'sd13421773;
        if (k == 3'd2) c = -25'sd3355443;
        if (k == 3'd3) c = 25'sd639132;
        if (k == 3'd4) c = -25'sd59919;
      end
    endcase
    return c;
  endfunction

  // drop fraction rounding half up, then saturate
  function automatic grad_t finish(input acc_t acc);
    acc_t                       biased;
    logic signed [ACC_W-FRAC_W-1:0] q;
    grad_t                      r;
    biased = acc + (acc_t'(1) <<< (FRAC_W - 1));
    q = biased[ACC_W-1:FRAC_W];
    if (q > $signed((ACC_W-FRAC_W)'({1'b0, {(OUT_W-1){1'b1}}}))) begin
      r = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (q < $signed({{(ACC_W-FRAC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}})) begin
      r = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      r = q[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/cdg_ram.sv -----
// generic single-write dual-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module cdg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

// ----- src/central_difference_gradient_2d_top.sv -----
// top level of the streaming central difference gradient over a haloed frame
//
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready  | in_sample
// out     | output    | out_valid/out_ready| out_grad_x, out_grad_y, out_center_column,
//         |           |                    | out_center_row, out_frame_end
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one sample per cycle sustained while the output is not stalled; the result for centre (c, r) is offered
// after sample (c, r+4) is taken, through registers: ram read, product, sum, round and saturate
// the eight lines sit side by side in one word of the line ram, read and written back once
// per sample; the write of column c is made once its read word moves on from stage 1
// reset clears control and loads the default configuration; line contents are undefined until written
// a stalled output only stops intake once every stage behind it holds a request
`timescale 1ns / 1ps
`default_nettype none
module central_difference_gradient_2d_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [cdg_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [cdg_pkg::OUT_W-1:0]      out_grad_x,
  output logic signed [cdg_pkg::OUT_W-1:0]      out_grad_y,
  output logic [cdg_pkg::COL_W-1:0]             out_center_column,
  output logic [cdg_pkg::ROW_W-1:0]             out_center_row,
  output logic                                  out_frame_end,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cdg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cdg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // configuration
  logic [cdg_pkg::ORDER_W-1:0] order_r;
  logic [cdg_pkg::FW_W-1:0]    fw_r;
  logic [cdg_pkg::FH_W-1:0]    fh_r;
  logic [cdg_pkg::FW_W-1:0]    w_eff;
  logic [cdg_pkg::FH_W-1:0]    h_eff;
  logic [cdg_pkg::ORDER_W-1:0] n_eff;
  logic                        cfg_we;
  logic                        geom_we;

  // raster position
  logic [cdg_pkg::COL_W-1:0] col_r, col_nxt;
  logic [cdg_pkg::ROW_W-1:0] row_r, row_nxt;
  logic                      accept;
  logic                      emit0;
  logic                      fe0;
  logic                      col_last;
  logic                      row_last;

  // pipeline handshake
  logic rdy1, rdy2, rdy3, rdy_out;
  logic v1_r, v2_r, v3_r;

  // stage 1: ram data plus item
  cdg_pkg::sample_t          s1_sample_r;
  logic [cdg_pkg::COL_W-1:0] s1_col_r;
  logic [cdg_pkg::ROW_W-1:0] s1_row_r;
  logic [cdg_pkg::LANE_W-1:0] s1_lane_r;
  logic                      s1_emit_r;
  logic                      s1_fe_r;
  logic [cdg_pkg::WORD_W-1:0] rd_a, rd_b, wr_word;
  logic                      ram_we;

  cdg_pkg::sample_t ha_r [4];
  cdg_pkg::sample_t hb_r [3];
  cdg_pkg::sample_t taps [9];
  cdg_pkg::sample_t up_v [4];
  cdg_pkg::sample_t dn_v [4];
  cdg_pkg::sample_t ctr_a, new_b;
  cdg_pkg::prod_t   px_nxt [4];
  cdg_pkg::prod_t   py_nxt [4];

  // stage 2: products
  cdg_pkg::prod_t            px_r [4];
  cdg_pkg::prod_t            py_r [4];
  logic [cdg_pkg::COL_W-1:0] s2_col_r;
  logic [cdg_pkg::ROW_W-1:0] s2_row_r;
  logic                      s2_fe_r;

  // stage 3: sums
  cdg_pkg::acc_t             ax_r, ay_r;
  cdg_pkg::acc_t             ax_nxt, ay_nxt;
  logic [cdg_pkg::COL_W-1:0] s3_col_r;
  logic [cdg_pkg::ROW_W-1:0] s3_row_r;
  logic                      s3_fe_r;

  logic out_valid_r;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign geom_we   = cfg_we && (cfg_index == cdg_pkg::CFG_WIDTH ||
                                cfg_index == cdg_pkg::CFG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= cdg_pkg::ORDER_RESET;
      fw_r    <= cdg_pkg::FW_RESET;
      fh_r    <= cdg_pkg::FH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cdg_pkg::CFG_ORDER:  order_r <= cfg_data[cdg_pkg::ORDER_W-1:0];
        cdg_pkg::CFG_WIDTH:  fw_r    <= cfg_data[cdg_pkg::FW_W-1:0];
        cdg_pkg::CFG_HEIGHT: fh_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_r < cdg_pkg::FW_W'(2 * cdg_pkg::HALO + 1)) begin
      w_eff = cdg_pkg::FW_W'(2 * cdg_pkg::HALO + 1);
    end else if (fw_r > cdg_pkg::FW_W'(cdg_pkg::MAX_WIDTH)) begin
      w_eff = cdg_pkg::FW_W'(cdg_pkg::MAX_WIDTH);
    end else begin
      w_eff = fw_r;
    end
    if (fh_r < cdg_pkg::FH_W'(2 * cdg_pkg::HALO + 1)) begin
      h_eff = cdg_pkg::FH_W'(2 * cdg_pkg::HALO + 1);
    end else if (fh_r > cdg_pkg::FH_W'(cdg_pkg::MAX_HEIGHT)) begin
      h_eff = cdg_pkg::FH_W'(cdg_pkg::MAX_HEIGHT);
    end else begin
      h_eff = fh_r;
    end
    if (order_r == '0) begin
      n_eff = 3'd1;
    end else if (order_r > 3'd4) begin
      n_eff = 3'd4;
    end else begin
      n_eff = order_r;
    end
  end

  // raster counters
  assign accept   = in_valid && in_ready;
  assign col_last = ({1'b0, col_r} + cdg_pkg::FW_W'(1)) == w_eff;
  assign row_last = ({1'b0, row_r} + cdg_pkg::FH_W'(1)) == h_eff;
  assign emit0    = (row_r >= cdg_pkg::ROW_W'(2 * cdg_pkg::HALO)) &&
                    (col_r >= cdg_pkg::COL_W'(cdg_pkg::HALO)) &&
                    (({1'b0, col_r} + cdg_pkg::FW_W'(cdg_pkg::HALO)) < w_eff);
  assign fe0      = (({1'b0, col_r} + cdg_pkg::FW_W'(cdg_pkg::HALO + 1)) == w_eff) &&
                    row_last;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (geom_we) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + cdg_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + cdg_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage enables, each stage moves when the one after it has room
  assign rdy_out  = !out_valid_r || out_ready;
  assign rdy3     = !v3_r || rdy_out;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // line ram: port a reads the current column, port b the centre row four columns ahead
  cdg_ram #(
    .WIDTH(cdg_pkg::WORD_W),
    .DEPTH(cdg_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (s1_col_r),
    .wdata   (wr_word),
    .re      (rdy1),
    .raddr_a (col_r),
    .raddr_b (col_r + cdg_pkg::COL_W'(cdg_pkg::HALO)),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_sample_r <= in_sample;
      s1_col_r    <= col_r;
      s1_row_r    <= row_r - cdg_pkg::ROW_W'(cdg_pkg::HALO);
      s1_lane_r   <= row_r[cdg_pkg::LANE_W-1:0] + cdg_pkg::LANE_W'(cdg_pkg::HALO);
      s1_emit_r   <= emit0;
      s1_fe_r     <= fe0;
    end
  end

  // s1_lane_r is the slot of the centre row; the new sample replaces slot centre+4
  assign ram_we = v1_r && rdy2;

  always_comb begin
    logic [cdg_pkg::LANE_W-1:0] wl;
    wl      = s1_lane_r + cdg_pkg::LANE_W'(cdg_pkg::HALO);
    wr_word = rd_a;
    wr_word[wl*cdg_pkg::SAMPLE_W +: cdg_pkg::SAMPLE_W] = s1_sample_r;
  end

  always_comb begin
    ctr_a = rd_a[s1_lane_r*cdg_pkg::SAMPLE_W +: cdg_pkg::SAMPLE_W];
    new_b = rd_b[s1_lane_r*cdg_pkg::SAMPLE_W +: cdg_pkg::SAMPLE_W];
    for (int i = 0; i < 4; i++) begin
      taps[i] = ha_r[i];
    end
    taps[4] = ctr_a;
    for (int i = 0; i < 3; i++) begin
      taps[5+i] = hb_r[i];
    end
    taps[8] = new_b;
    for (int k = 1; k <= 4; k++) begin
      logic [cdg_pkg::LANE_W-1:0] lu, ld;
      lu = s1_lane_r + cdg_pkg::LANE_W'(k);
      ld = s1_lane_r - cdg_pkg::LANE_W'(k);
      up_v[k-1] = (k == cdg_pkg::HALO) ? s1_sample_r :
                  rd_a[lu*cdg_pkg::SAMPLE_W +: cdg_pkg::SAMPLE_W];
      dn_v[k-1] = rd_a[ld*cdg_pkg::SAMPLE_W +: cdg_pkg::SAMPLE_W];
    end
  end

  always_comb begin
    for (int k = 1; k <= 4; k++) begin
      logic signed [cdg_pkg::DIFF_W-1:0] dx, dy;
      cdg_pkg::coef_t                    c;
      dx = cdg_pkg::DIFF_W'(taps[4+k]) - cdg_pkg::DIFF_W'(taps[4-k]);
      dy = cdg_pkg::DIFF_W'(up_v[k-1]) - cdg_pkg::DIFF_W'(dn_v[k-1]);
      c  = cdg_pkg::coef(n_eff, 3'(k));
      px_nxt[k-1] = cdg_pkg::PROD_W'(dx) * cdg_pkg::PROD_W'(c);
      py_nxt[k-1] = cdg_pkg::PROD_W'(dy) * cdg_pkg::PROD_W'(c);
    end
  end

  // horizontal window of the centre row, shifted once per sample
  always_ff @(posedge clk) begin
    if (ram_we) begin
      ha_r[0] <= ha_r[1];
      ha_r[1] <= ha_r[2];
      ha_r[2] <= ha_r[3];
      ha_r[3] <= ctr_a;
      hb_r[0] <= hb_r[1];
      hb_r[1] <= hb_r[2];
      hb_r[2] <= new_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      px_r     <= px_nxt;
      py_r     <= py_nxt;
      s2_col_r <= s1_col_r;
      s2_row_r <= s1_row_r;
      s2_fe_r  <= s1_fe_r;
    end
  end

  always_comb begin
    ax_nxt = '0;
    ay_nxt = '0;
    for (int k = 0; k < 4; k++) begin
      ax_nxt = ax_nxt + cdg_pkg::ACC_W'(px_r[k]);
      ay_nxt = ay_nxt + cdg_pkg::ACC_W'(py_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      ax_r     <= ax_nxt;
      ay_r     <= ay_nxt;
      s3_col_r <= s2_col_r;
      s3_row_r <= s2_row_r;
      s3_fe_r  <= s2_fe_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_grad_x        <= cdg_pkg::finish(ax_r);
      out_grad_y        <= cdg_pkg::finish(ay_r);
      out_center_column <= s3_col_r;
      out_center_row    <= s3_row_r;
      out_frame_end     <= s3_fe_r;
    end
  end

  assign out_valid = out_valid_r;

  // a write-back never meets a read of the same column
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && accept |-> s1_col_r != col_r)
    else $error("line ram write and read hit the same column");

  // the raster position stays inside the frame
  assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r} < w_eff) && ({1'b0, row_r} < h_eff))
    else $error("raster position outside frame");

  // frame end only on the last owned column
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |->
      ({1'b0, out_center_column} + cdg_pkg::FW_W'(cdg_pkg::HALO + 1)) == w_eff)
    else $error("frame end on wrong column");

  // results only for owned centre columns
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_center_column >= cdg_pkg::COL_W'(cdg_pkg::HALO))
    else $error("result for a halo column");

  // reset empties the pipeline
  assert property (@(posedge clk) !rst_n |=> !out_valid && !v1_r && !v2_r && !v3_r)
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for the haloed central difference gradient block
`timescale 1ns / 1ps
module testbench;

  localparam int STUCK_LIMIT = 4000;
  // index with no register behind it
  localparam logic [cdg_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {PAT_FLAT, PAT_RAMP, PAT_CHECK, PAT_RAND} pattern_t;

  typedef struct {
    cdg_pkg::grad_t            gx;
    cdg_pkg::grad_t            gy;
    logic [cdg_pkg::COL_W-1:0] col;
    logic [cdg_pkg::ROW_W-1:0] row;
    logic                      fe;
  } grad_rec_t;

  typedef struct {
    bit                             is_cfg;
    logic [cdg_pkg::CFG_IDX_W-1:0]  idx;
    logic [cdg_pkg::CFG_DATA_W-1:0] data;
    pattern_t                       pat;
    cdg_pkg::sample_t               base;
    int                             reps;
    bit                             flat;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  cdg_pkg::sample_t in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cdg_pkg::grad_t out_grad_x, out_grad_y;
  logic [cdg_pkg::COL_W-1:0] out_center_column;
  logic [cdg_pkg::ROW_W-1:0] out_center_row;
  logic out_frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cdg_pkg::CFG_IDX_W-1:0] cfg_index = cdg_pkg::CFG_ORDER;
  logic [cdg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  central_difference_gradient_2d_top dut (.*);

  always #6 clk = ~clk;

  // gradient model state
  logic [cdg_pkg::ORDER_W-1:0] m_order;
  logic [cdg_pkg::FW_W-1:0]    m_width;
  logic [cdg_pkg::FH_W-1:0]    m_height;
  cdg_pkg::sample_t            m_lines [cdg_pkg::LINES][cdg_pkg::MAX_WIDTH];
  int                          m_col, m_row;
  longint                      weight [4][4];

  grad_rec_t pending_grads[$];
  plan_row_t plan[$];
  int  errors = 0;
  int  samples_sent = 0;
  int  grads_predicted = 0;
  int  grads_checked = 0;
  int  cfg_writes = 0;
  int  stuck = 0;
  bit  calm = 1'b0;
  bit  squeeze = 1'b0;

  function automatic longint qcoef(int num, int den);
    return ((longint'(num) <<< (cdg_pkg::FRAC_W + 1)) + den) / (2 * den);
  endfunction

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // round half up, then saturate to the output width
  function automatic cdg_pkg::grad_t round_sat(longint acc);
    longint t, hi;
    hi = (longint'(1) <<< (cdg_pkg::OUT_W - 1)) - 1;
    t = (acc + (longint'(1) <<< (cdg_pkg::FRAC_W - 1))) >>> cdg_pkg::FRAC_W;
    if (t > hi) t = hi;
    if (t < -hi - 1) t = -hi - 1;
    return cdg_pkg::grad_t'(t);
  endfunction

  function automatic plan_row_t cfg_row(logic [cdg_pkg::CFG_IDX_W-1:0] idx, int data);
    plan_row_t p;
    p = '{1'b1, idx, cdg_pkg::CFG_DATA_W'(data), PAT_FLAT, '0, 0, 1'b0};
    return p;
  endfunction

  function automatic plan_row_t run_row(pattern_t pat, cdg_pkg::sample_t base, int reps,
                                        bit flat);
    plan_row_t p;
    p = '{1'b0, cdg_pkg::CFG_ORDER, '0, pat, base, reps, flat};
    return p;
  endfunction

  function automatic cdg_pkg::sample_t rand_sample();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return cdg_pkg::sample_t'($signed($urandom_range(0, 64)) - 32);
      default: return cdg_pkg::sample_t'($urandom);
    endcase
  endfunction

  function automatic cdg_pkg::sample_t make_sample(pattern_t pat, cdg_pkg::sample_t base,
                                                   int i);
    case (pat)
      PAT_FLAT:  return base;
      PAT_RAMP:  return cdg_pkg::sample_t'(base * i);
      PAT_CHECK: return ((m_col + m_row) % 2) ? 32'sh7fffffff : 32'sh80000000;
      default:   return rand_sample();
    endcase
  endfunction

  task automatic model_reset();
    m_order = cdg_pkg::ORDER_RESET;
    m_width = cdg_pkg::FW_RESET;
    m_height = cdg_pkg::FH_RESET;
    m_col = 0;
    m_row = 0;
    foreach (m_lines[i, j]) m_lines[i][j] = '0;
  endtask

  task automatic model_cfg(logic [cdg_pkg::CFG_IDX_W-1:0] idx,
                           logic [cdg_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      cdg_pkg::CFG_ORDER: m_order = data[cdg_pkg::ORDER_W-1:0];
      cdg_pkg::CFG_WIDTH: begin
        m_width = data[cdg_pkg::FW_W-1:0];
        m_col = 0;
        m_row = 0;
      end
      cdg_pkg::CFG_HEIGHT: begin
        m_height = data[cdg_pkg::FH_W-1:0];
        m_col = 0;
        m_row = 0;
      end
      default: ;
    endcase
  endtask

  // advance the model by one sample, queue the gradient it produces
  task automatic predict_gradient(cdg_pkg::sample_t s, bit flat);
    int w, h, n, col, row, r, k;
    longint ax, ay, up, dn;
    cdg_pkg::sample_t win [2*cdg_pkg::HALO+1];
    grad_rec_t g;
    w = clampi(m_width, 2*cdg_pkg::HALO+1, cdg_pkg::MAX_WIDTH);
    h = clampi(m_height, 2*cdg_pkg::HALO+1, cdg_pkg::MAX_HEIGHT);
    n = clampi(m_order, 1, cdg_pkg::HALO);
    col = (m_col >= w) ? w - 1 : m_col;
    row = (m_row >= h) ? h - 1 : m_row;
    if (row >= 2*cdg_pkg::HALO && col >= cdg_pkg::HALO && col + cdg_pkg::HALO < w) begin
      r = row - cdg_pkg::HALO;
      ax = 0;
      ay = 0;
      for (k = 0; k <= 2*cdg_pkg::HALO; k++) begin
        win[k] = m_lines[r % cdg_pkg::LINES][col - cdg_pkg::HALO + k];
      end
      for (k = 1; k <= n; k++) begin
        up = (k == cdg_pkg::HALO) ? longint'(s) :
             longint'(m_lines[(r + k) % cdg_pkg::LINES][col]);
        dn = longint'(m_lines[(r - k) % cdg_pkg::LINES][col]);
        ax += weight[n-1][k-1] *
              (longint'(win[cdg_pkg::HALO+k]) - longint'(win[cdg_pkg::HALO-k]));
        ay += weight[n-1][k-1] * (up - dn);
      end
      g.gx = flat ? cdg_pkg::grad_t'(0) : round_sat(ax);
      g.gy = flat ? cdg_pkg::grad_t'(0) : round_sat(ay);
      g.col = cdg_pkg::COL_W'(col);
      g.row = cdg_pkg::ROW_W'(r);
      g.fe = (col == w - 1 - cdg_pkg::HALO && r == h - 1 - cdg_pkg::HALO);
      pending_grads.push_back(g);
      grads_predicted++;
    end
    m_lines[row % cdg_pkg::LINES][col] = s;
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    m_col = col;
    m_row = row;
  endtask

  task automatic send_sample(cdg_pkg::sample_t s, bit flat);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    predict_gradient(s, flat);
    samples_sent++;
  endtask

  task automatic send_run(pattern_t pat, cdg_pkg::sample_t base, int reps, bit flat);
    for (int i = 0; i < reps; i++) send_sample(make_sample(pat, base, i), flat);
    in_valid <= 1'b0;
  endtask

  // registers change only with the pipeline drained
  task automatic write_reg(logic [cdg_pkg::CFG_IDX_W-1:0] idx,
                           logic [cdg_pkg::CFG_DATA_W-1:0] data);
    while (pending_grads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_cfg(idx, data);
    cfg_writes++;
  endtask

  // result side: random stalls, one long hold when asked
  initial begin
    int stall;
    grad_rec_t g;
    wait (rst_n);
    forever begin
      stall = ((grads_checked / 40) % 3 == 2) ? 0 : $urandom_range(0, 12);
      if (squeeze) begin
        squeeze = 1'b0;
        stall = 300;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      grads_checked++;
      if (pending_grads.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected gradient at col %0d row %0d",
                                   out_center_column, out_center_row);
      end else begin
        g = pending_grads.pop_front();
        if (out_grad_x !== g.gx || out_grad_y !== g.gy || out_center_column !== g.col ||
            out_center_row !== g.row || out_frame_end !== g.fe) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: got gx=%0d gy=%0d c=%0d r=%0d fe=%0b",
                     out_grad_x, out_grad_y, out_center_column, out_center_row,
                     out_frame_end);
            $display("          want gx=%0d gy=%0d c=%0d r=%0d fe=%0b",
                     g.gx, g.gy, g.col, g.row, g.fe);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stuck <= 0;
      end else begin
        stuck <= stuck + 1;
      end
      if (stuck == STUCK_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", STUCK_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int ph, w, h, reps, rand_start;
    int wdata, hdata;
    weight[0] = '{qcoef(1, 2), 0, 0, 0};
    weight[1] = '{qcoef(2, 3), -qcoef(1, 12), 0, 0};
    weight[2] = '{qcoef(3, 4), -qcoef(3, 20), qcoef(1, 60), 0};
    weight[3] = '{qcoef(4, 5), -qcoef(1, 5), qcoef(4, 105), -qcoef(1, 280)};
    model_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: the first rows are halo, so nothing may come out
    send_run(PAT_RAND, '0, 64, 1'b0);

    plan.push_back(cfg_row(cdg_pkg::CFG_WIDTH, 9));
    plan.push_back(cfg_row(cdg_pkg::CFG_HEIGHT, 9));
    plan.push_back(cfg_row(cdg_pkg::CFG_ORDER, 4));
    plan.push_back(run_row(PAT_FLAT, 32'sh7fffffff, 81, 1'b1));
    plan.push_back(run_row(PAT_FLAT, 32'sh80000000, 81, 1'b1));
    plan.push_back(cfg_row(cdg_pkg::CFG_ORDER, 1));
    plan.push_back(run_row(PAT_CHECK, '0, 81, 1'b0));
    plan.push_back(cfg_row(cdg_pkg::CFG_ORDER, 0));
    plan.push_back(run_row(PAT_RAMP, 1000, 81, 1'b0));
    plan.push_back(cfg_row(cdg_pkg::CFG_ORDER, 7));
    plan.push_back(run_row(PAT_RAND, '0, 81, 1'b0));
    plan.push_back(cfg_row(cdg_pkg::CFG_ORDER, 3));
    plan.push_back(run_row(PAT_CHECK, '0, 81, 1'b0));
    plan.push_back(cfg_row(cdg_pkg::CFG_ORDER, 2));
    plan.push_back(cfg_row(CFG_SPARE, 13'h1fff));
    plan.push_back(run_row(PAT_RAMP, -77, 81, 1'b0));
    plan.push_back(cfg_row(cdg_pkg::CFG_WIDTH, 3));
    plan.push_back(cfg_row(cdg_pkg::CFG_HEIGHT, 0));
    plan.push_back(run_row(PAT_RAND, '0, 162, 1'b0));
    plan.push_back(cfg_row(cdg_pkg::CFG_WIDTH, 13'h1800 | 12));
    plan.push_back(cfg_row(cdg_pkg::CFG_HEIGHT, 10));
    plan.push_back(run_row(PAT_FLAT, '0, 120, 1'b1));
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_run(plan[i].pat, plan[i].base, plan[i].reps, plan[i].flat);
      end
    end

    rand_start = samples_sent;
    ph = 0;
    while (samples_sent - rand_start < 700 || ph < 4) begin
      if (ph == 3) begin
        wdata = 13'h7ff;
      end else if ($urandom_range(0, 7) == 0) begin
        wdata = $urandom_range(0, 8);
      end else begin
        wdata = $urandom_range(9, 24) | ($urandom_range(0, 3) << cdg_pkg::FW_W);
      end
      case ($urandom_range(0, 7))
        0: hdata = $urandom_range(4097, 8191);
        1: hdata = $urandom_range(0, 8);
        default: hdata = $urandom_range(9, 16);
      endcase
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, cdg_pkg::CFG_DATA_W'($urandom));
      write_reg(cdg_pkg::CFG_ORDER, cdg_pkg::CFG_DATA_W'($urandom_range(0, 7)));
      write_reg(cdg_pkg::CFG_WIDTH, cdg_pkg::CFG_DATA_W'(wdata));
      write_reg(cdg_pkg::CFG_HEIGHT, cdg_pkg::CFG_DATA_W'(hdata));
      w = clampi(wdata & 12'h7ff, 2*cdg_pkg::HALO+1, cdg_pkg::MAX_WIDTH);
      h = clampi(hdata, 2*cdg_pkg::HALO+1, cdg_pkg::MAX_HEIGHT);
      // a wide frame only gets its halo rows started
      reps = (w > 64) ? 100 :
             w * clampi(h, 2*cdg_pkg::HALO+1, 20) * $urandom_range(1, 2);
      calm = (ph == 1) || ($urandom_range(0, 3) == 0);
      squeeze = (ph == 1);
      send_run(PAT_RAND, '0, reps, 1'b0);
      calm = 1'b0;
      ph++;
    end

    while (pending_grads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d samples over %0d geometry phases, %0d gradients checked, %0d register writes",
             samples_sent, ph + 1, grads_checked, cfg_writes);
    $display("orders 0..7, clamped and oversized frames, flat and checkerboard fields, %0d errors",
             errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
